>>> sv/khrd_pkg.sv
// Shared constants and types for the keyed hash random draw core.
`default_nettype none
package khrd_pkg;

    localparam logic [63:0] GOLDEN_STEP = 64'h9e3779b97f4a7c15;
    localparam logic [63:0] MUL_FIRST   = 64'hbf58476d1ce4e5b9;
    localparam logic [63:0] MUL_SECOND  = 64'h94d049bb133111eb;
    localparam int unsigned SHIFT_A     = 30;
    localparam int unsigned SHIFT_B     = 27;
    localparam int unsigned SHIFT_C     = 31;

    // Register stages through one finalizer.
    localparam int FIN_LAT = 5;

    localparam logic [32:0] UNIT_ONE = 33'h1_0000_0000;

    // Request fields that ride alongside the hash.
    typedef struct packed {
        logic               action;
        logic [32:0]        chance;
        logic signed [31:0] lower_bound;
        logic signed [31:0] upper_bound;
    } t_side;

endpackage
`default_nettype wire

>>> sv/khrd_fin.sv
// Five-stage pipelined 64-bit finalizer mix (add, then xor-shift and multiply twice, then a final xor-shift).
`default_nettype none
module khrd_fin
    import khrd_pkg::*;
(
    input  wire logic        i_clk,
    input  wire logic [63:0] i_x,
    output logic      [63:0] o_y
);

    logic [63:0] r_a, r_b, r_y;
    logic [63:0] r_p0, r_q0;
    logic [31:0] r_p1, r_p2, r_q1, r_q2;
    logic [63:0] n_v, n_m1, n_m2;

    always_comb begin
        n_v  = i_x + GOLDEN_STEP;
        n_m1 = r_p0 + {r_p1 + r_p2, 32'd0};
        n_m2 = r_q0 + {r_q1 + r_q2, 32'd0};
    end

    // Low 64 bits of a 64x64 product from three 32x32 partial products.
    always_ff @(posedge i_clk) begin
        r_a  <= n_v ^ (n_v >> SHIFT_A);
        r_p0 <= {32'd0, r_a[31:0]} * {32'd0, MUL_FIRST[31:0]};
        r_p1 <= r_a[31:0] * MUL_FIRST[63:32];
        r_p2 <= r_a[63:32] * MUL_FIRST[31:0];
        r_b  <= n_m1 ^ (n_m1 >> SHIFT_B);
        r_q0 <= {32'd0, r_b[31:0]} * {32'd0, MUL_SECOND[31:0]};
        r_q1 <= r_b[31:0] * MUL_SECOND[63:32];
        r_q2 <= r_b[63:32] * MUL_SECOND[31:0];
        r_y  <= n_m2 ^ (n_m2 >> SHIFT_C);
    end

    assign o_y = r_y;

endmodule
`default_nettype wire

>>> sv/khrd_draw.sv
// Draw stage: chance compare and pipelined 64-bit modulo by the bound span.
`default_nettype none
module khrd_draw
    import khrd_pkg::*;
(
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_valid,
    input  wire logic [63:0] i_hash,
    input  wire t_side       i_side,
    output logic             o_valid,
    output logic             o_success,
    output logic signed [31:0] o_drawn_value
);

    localparam int Steps = 32;
    localparam int BitsPerStep = 64 / Steps;

    logic [63:0] r_dvd  [0:Steps];
    logic [32:0] r_rem  [0:Steps];
    logic [32:0] r_span [0:Steps];
    t_side       r_side [0:Steps];
    logic        r_hit  [0:Steps];
    logic        r_vld  [0:Steps];

    logic [32:0] n_span;
    logic [32:0] n_unit;
    logic        n_hit;

    always_comb begin
        n_span = {i_side.upper_bound[31], i_side.upper_bound}
               - {i_side.lower_bound[31], i_side.lower_bound} + 33'd1;
        n_unit = {1'b0, i_hash[31:0]} + {32'd0, &i_hash[31:0]};
        n_hit  = (i_side.chance == UNIT_ONE) || (n_unit < i_side.chance);
    end

    always_ff @(posedge i_clk) begin
        r_dvd[0]  <= i_hash;
        r_rem[0]  <= '0;
        r_span[0] <= n_span;
        r_side[0] <= i_side;
        r_hit[0]  <= n_hit;
    end

    // Restoring division, two quotient bits per stage; only the remainder is kept.
    for (genvar k = 1; k <= Steps; k++) begin : g_step
        logic [63:0] n_dvd;
        logic [32:0] n_rem;
        logic [33:0] n_try;

        always_comb begin
            n_dvd = r_dvd[k-1];
            n_rem = r_rem[k-1];
            n_try = '0;
            for (int b = 0; b < BitsPerStep; b++) begin
                n_try = {n_rem, n_dvd[63]};
                n_dvd = {n_dvd[62:0], 1'b0};
                if (n_try >= {1'b0, r_span[k-1]}) begin
                    n_try = n_try - {1'b0, r_span[k-1]};
                end
                n_rem = n_try[32:0];
            end
        end

        always_ff @(posedge i_clk) begin
            r_dvd[k]  <= n_dvd;
            r_rem[k]  <= n_rem;
            r_span[k] <= r_span[k-1];
            r_side[k] <= r_side[k-1];
            r_hit[k]  <= r_hit[k-1];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k <= Steps; k++) r_vld[k] <= 1'b0;
        end else begin
            r_vld[0] <= i_valid;
            for (int k = 1; k <= Steps; k++) r_vld[k] <= r_vld[k-1];
        end
    end

    logic               r_valid;
    logic               r_success;
    logic signed [31:0] r_drawn;
    logic signed [31:0] n_drawn;
    t_side              w_side;

    always_comb begin
        w_side = r_side[Steps];
        if (!w_side.action) begin
            n_drawn = '0;
        end else if (w_side.lower_bound == w_side.upper_bound) begin
            n_drawn = w_side.lower_bound;
        end else if (w_side.lower_bound > w_side.upper_bound) begin
            n_drawn = w_side.upper_bound;
        end else begin
            n_drawn = w_side.lower_bound + $signed(r_rem[Steps][31:0]);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= r_vld[Steps];
        end
        r_success <= r_hit[Steps] & ~w_side.action;
        r_drawn   <= n_drawn;
    end

    assign o_valid       = r_valid;
    assign o_success     = r_success;
    assign o_drawn_value = r_drawn;

endmodule
`default_nettype wire

>>> sv/keyed_hash_random_draw_core.sv
// Top level of the keyed hash random draw core.
//
// Requests enter on start with all fields on their own ports; the core
// takes one request in every cycle, so busy stays low. Each request
// produces exactly one result on o_success / o_drawn_value, marked by a
// one-cycle o_done strobe, in request order.
// A request passes through the four parallel key finalizers, the final
// finalizer, the span and chance compare register, the modulo pipeline
// (two dividend bits per stage) and the output register.
// Throughput is one request per cycle.
// The seed is written over the cfg channel (always ready) and should
// change only while no request is in flight.
// Synchronous active-low reset clears the seed to zero and drops every
// request in flight. The receiver cannot stall; o_done is not held.
`default_nettype none
module keyed_hash_random_draw_core
    import khrd_pkg::*;
(
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               start,
    output logic                    busy,
    input  wire logic               i_action,
    input  wire logic [31:0]        i_crate_id,
    input  wire logic [31:0]        i_picker_id,
    input  wire logic [31:0]        i_authored_order,
    input  wire logic [63:0]        i_confirmed_tick,
    input  wire logic [63:0]        i_purpose,
    input  wire logic [32:0]        i_chance,
    input  wire logic signed [31:0] i_lower_bound,
    input  wire logic signed [31:0] i_upper_bound,
    input  wire logic               i_cfg_valid,
    output logic                    o_cfg_ready,
    input  wire logic [63:0]        i_cfg_data,
    output logic                    o_done,
    output logic                    o_success,
    output logic signed [31:0]      o_drawn_value
);

    localparam int HashLat = 2 * FIN_LAT;

    logic [63:0] r_seed;
    logic        w_accept;

    assign busy        = 1'b0;
    assign o_cfg_ready = 1'b1;
    assign w_accept    = start & ~busy;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_seed <= '0;
        end else if (i_cfg_valid && o_cfg_ready) begin
            r_seed <= i_cfg_data;
        end
    end

    logic [63:0] w_f_seed, w_f_crate, w_f_key, w_f_tick, w_hash;
    logic [63:0] n_mix;

    khrd_fin u_fin_seed  (.i_clk(i_clk), .i_x(r_seed),                        .o_y(w_f_seed));
    khrd_fin u_fin_crate (.i_clk(i_clk), .i_x({32'd0, i_crate_id}),          .o_y(w_f_crate));
    khrd_fin u_fin_key   (.i_clk(i_clk), .i_x({i_picker_id, i_authored_order}), .o_y(w_f_key));
    khrd_fin u_fin_tick  (.i_clk(i_clk), .i_x(i_confirmed_tick),             .o_y(w_f_tick));

    logic [63:0] r_purpose [0:FIN_LAT-1];
    t_side       r_side    [0:HashLat-1];
    logic        r_vld     [0:HashLat-1];

    assign n_mix = w_f_seed ^ w_f_crate ^ w_f_key ^ w_f_tick ^ r_purpose[FIN_LAT-1];

    khrd_fin u_fin_final (.i_clk(i_clk), .i_x(n_mix), .o_y(w_hash));

    always_ff @(posedge i_clk) begin
        r_purpose[0] <= i_purpose;
        for (int k = 1; k < FIN_LAT; k++) r_purpose[k] <= r_purpose[k-1];
        r_side[0] <= '{action: i_action, chance: i_chance,
                       lower_bound: i_lower_bound, upper_bound: i_upper_bound};
        for (int k = 1; k < HashLat; k++) r_side[k] <= r_side[k-1];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < HashLat; k++) r_vld[k] <= 1'b0;
        end else begin
            r_vld[0] <= w_accept;
            for (int k = 1; k < HashLat; k++) r_vld[k] <= r_vld[k-1];
        end
    end

    khrd_draw u_draw (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_valid       (r_vld[HashLat-1]),
        .i_hash        (w_hash),
        .i_side        (r_side[HashLat-1]),
        .o_valid       (o_done),
        .o_success     (o_success),
        .o_drawn_value (o_drawn_value)
    );

endmodule
`default_nettype wire
